// ===== rtl/core/pll_divider_search_top_macros.svh =====
// Assertion macros for the PLL divider search block; they expect clk and rst_n in scope.
`ifndef PLL_DIVIDER_SEARCH_TOP_MACROS_SVH
`define PLL_DIVIDER_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define PDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define PDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pds_pkg.sv =====
// Package with the types, constants and microprogram of the PLL divider search.
`timescale 1ns / 1ps
package pds_pkg;

  localparam int REF_W   = 26;
  localparam int FREQ_W  = 27;
  localparam int TGT_W   = 32;
  localparam int N_W     = 7;
  localparam int RC_W    = 2;
  localparam int MV_W    = 4;
  localparam int WS_W    = 3;
  localparam int CFG_W   = 27;
  localparam int CFG_IDX_W = 1;

  localparam int R_CHOICES_DEF = 4;
  localparam int M_MAX_DEF     = 8;

  localparam logic [REF_W-1:0]  REF_RST   = 26'd4000000;
  localparam logic [FREQ_W-1:0] START_RST = 27'd4000000;

  localparam logic [TGT_W-1:0]  FREQ_MIN = 32'd8000000;
  localparam logic [TGT_W-1:0]  FREQ_MAX = 32'd80000000;
  localparam logic [REF_W-1:0]  VIN_MIN  = 26'd4000000;
  localparam logic [REF_W-1:0]  VIN_MAX  = 26'd16000000;
  localparam logic [31:0]       VOUT_MIN = 32'd64000000;
  localparam logic [31:0]       VOUT_MAX = 32'd344000000;
  localparam logic [N_W-1:0]    N_MIN    = 7'd8;
  localparam logic [N_W-1:0]    N_MAX    = 7'd86;

  localparam logic [FREQ_W-1:0] WS0_LIM = 27'd16000000;
  localparam logic [FREQ_W-1:0] WS1_LIM = 27'd32000000;
  localparam logic [FREQ_W-1:0] WS2_LIM = 27'd48000000;
  localparam logic [FREQ_W-1:0] WS3_LIM = 27'd64000000;
  localparam logic [WS_W-1:0]   WS_TOP  = 3'd4;

  localparam logic OPC_INIT = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF   = 1'b0,
    CFG_START = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             opcode;
    logic [TGT_W-1:0] target_freq_hz;
  } in_t;

  typedef struct packed {
    logic              status;
    logic              settings_changed;
    logic [RC_W-1:0]   r_divider_code;
    logic [MV_W-1:0]   m_divider;
    logic [N_W-1:0]    n_multiplier;
    logic [WS_W-1:0]   wait_states;
    logic [FREQ_W-1:0] current_freq_hz;
  } out_t;

  // Datapath operations, one per control word.
  typedef enum logic [4:0] {
    OP_NOP, OP_ACCEPT, OP_CLR, OP_DIV_VIN, OP_LD_VIN, OP_MUL_TM, OP_MUL_R,
    OP_DIV_N, OP_LD_N, OP_MUL_VOUT, OP_MUL_REF_N, OP_DIV_F, OP_LD_FOUND,
    OP_INC_M, OP_INC_I, OP_LD_INIT, OP_SET_FAIL, OP_SET_OK, OP_EMIT
  } op_e;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [3:0] {
    C_NONE, C_ALWAYS, C_NO_IN, C_IS_INIT, C_BAD_RANGE, C_SAME, C_DIV_BUSY,
    C_VIN_BAD, C_N_BAD, C_VOUT_BAD, C_M_LAST, C_R_LAST, C_OUT_FULL
  } cond_e;

  localparam int NSTEPS = 27;
  localparam int STEP_W = $clog2(NSTEPS);

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic is_init;
    logic bad_range;
    logic same;
    logic div_busy;
    logic vin_bad;
    logic n_bad;
    logic vout_bad;
    logic m_last;
    logic r_last;
    logic out_full;
  } flags_t;

  localparam logic [STEP_W-1:0] L_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] L_MLOOP    = 5'd5;
  localparam logic [STEP_W-1:0] L_DIVW_VIN = 5'd6;
  localparam logic [STEP_W-1:0] L_DIVW_N   = 5'd11;
  localparam logic [STEP_W-1:0] L_DIVW_F   = 5'd16;
  localparam logic [STEP_W-1:0] L_NEXT_M   = 5'd18;
  localparam logic [STEP_W-1:0] L_NEXT_R   = 5'd20;
  localparam logic [STEP_W-1:0] L_INIT     = 5'd22;
  localparam logic [STEP_W-1:0] L_FAIL     = 5'd23;
  localparam logic [STEP_W-1:0] L_OK       = 5'd24;
  localparam logic [STEP_W-1:0] L_EMIT     = 5'd25;

  // The microprogram. Steps that never jump carry L_IDLE as an unused target.
  localparam ctrl_t UCODE [NSTEPS] = '{
    '{OP_ACCEPT,    C_NO_IN,     L_IDLE},      //  0 wait for a transaction
    '{OP_NOP,       C_IS_INIT,   L_INIT},      //  1
    '{OP_NOP,       C_BAD_RANGE, L_FAIL},      //  2
    '{OP_NOP,       C_SAME,      L_OK},        //  3
    '{OP_CLR,       C_NONE,      L_IDLE},      //  4 first R, M = 1
    '{OP_DIV_VIN,   C_NONE,      L_IDLE},      //  5 vin = ref / M
    '{OP_NOP,       C_DIV_BUSY,  L_DIVW_VIN},  //  6
    '{OP_LD_VIN,    C_NONE,      L_IDLE},      //  7
    '{OP_MUL_TM,    C_VIN_BAD,   L_NEXT_R},    //  8 target * M
    '{OP_MUL_R,     C_NONE,      L_IDLE},      //  9 ... * R
    '{OP_DIV_N,     C_NONE,      L_IDLE},      // 10 N = ... / ref
    '{OP_NOP,       C_DIV_BUSY,  L_DIVW_N},    // 11
    '{OP_LD_N,      C_NONE,      L_IDLE},      // 12
    '{OP_MUL_VOUT,  C_N_BAD,     L_NEXT_M},    // 13 vout = vin * N
    '{OP_MUL_REF_N, C_VOUT_BAD,  L_NEXT_M},    // 14 ref * N
    '{OP_DIV_F,     C_NONE,      L_IDLE},      // 15 ... / (M * R)
    '{OP_NOP,       C_DIV_BUSY,  L_DIVW_F},    // 16
    '{OP_LD_FOUND,  C_ALWAYS,    L_EMIT},      // 17
    '{OP_INC_M,     C_M_LAST,    L_NEXT_R},    // 18
    '{OP_NOP,       C_ALWAYS,    L_MLOOP},     // 19
    '{OP_INC_I,     C_R_LAST,    L_FAIL},      // 20
    '{OP_NOP,       C_ALWAYS,    L_MLOOP},     // 21
    '{OP_LD_INIT,   C_ALWAYS,    L_EMIT},      // 22
    '{OP_SET_FAIL,  C_ALWAYS,    L_EMIT},      // 23
    '{OP_SET_OK,    C_NONE,      L_IDLE},      // 24
    '{OP_EMIT,      C_OUT_FULL,  L_EMIT},      // 25 hold until the output frees
    '{OP_NOP,       C_ALWAYS,    L_IDLE}       // 26
  };

endpackage

// ===== rtl/core/pds_stream_if.sv =====
// Valid/ready stream interface used by the input and result channels.
`timescale 1ns / 1ps
interface pds_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pll_divider_search_top.sv =====
// Top level of the PLL divider search block.
`timescale 1ns / 1ps
// The block takes one transaction at a time on the input channel and returns exactly one
// result transaction for it. An init transaction reloads the current frequency from the
// start frequency register; a request searches the output divider R over 2, 4, 6, ... and,
// inside each R, the reference divider M from 1 upwards for the first setting whose
// multiplier N and VCO frequency lie in range, then reports the codes, the frequency that
// results, its flash wait states and the stored current frequency. Init transactions,
// rejected targets and targets equal to the current frequency skip the search and go
// straight to the result. A search is paced by the shared restoring divider, which
// yields one quotient bit per cycle over a dividend of 27 + log2 R + log2 M bits (35 bits
// by default), and the sequencer waits on each division until the divider is done: each
// (R, M) pair tried costs up to two divisions, a found setting one more division, and at
// most R_CHOICES * M_MAX pairs are tried. A finished result waits in the output
// register while the next transaction is already accepted. The two configuration
// registers (reference and start frequency) are written through the plain write port
// and should only be written while the block is idle.
module pll_divider_search_top #(
  parameter int R_CHOICES = pds_pkg::R_CHOICES_DEF,
  parameter int M_MAX     = pds_pkg::M_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pds_stream_if.sink                    in_if,
  pds_stream_if.source                  out_if,
  input  logic                          cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pds_pkg::CFG_W-1:0]     cfg_wdata
);
  import pds_pkg::*;

  // Control word from the sequencer and status flags back from the datapath.
  ctrl_t  ctrl;
  flags_t flags;

  pds_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  pds_datapath #(
    .R_CHOICES (R_CHOICES),
    .M_MAX     (M_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );
endmodule

// ===== rtl/core/pds_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module pds_div #(
  parameter int DVD_W = 37,
  parameter int DVS_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dq_r;
endmodule

// ===== rtl/core/pds_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
module pds_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  pds_pkg::flags_t flags,
  output pds_pkg::ctrl_t  ctrl
);
  import pds_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              jump;

  assign ctrl = UCODE[step_r];

  always_comb begin
    case (ctrl.cond)
      C_NONE:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_IN:     jump = flags.no_in;
      C_IS_INIT:   jump = flags.is_init;
      C_BAD_RANGE: jump = flags.bad_range;
      C_SAME:      jump = flags.same;
      C_DIV_BUSY:  jump = flags.div_busy;
      C_VIN_BAD:   jump = flags.vin_bad;
      C_N_BAD:     jump = flags.n_bad;
      C_VOUT_BAD:  jump = flags.vout_bad;
      C_M_LAST:    jump = flags.m_last;
      C_R_LAST:    jump = flags.r_last;
      C_OUT_FULL:  jump = flags.out_full;
      default:     jump = 1'b0;
    endcase
  end

  assign step_nxt = jump ? ctrl.target : step_r + STEP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= L_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end
endmodule

// ===== rtl/core/pds_datapath.sv =====
// Search datapath: loop registers, shared multiplier, divider and result registers.
`timescale 1ns / 1ps
module pds_datapath #(
  parameter int R_CHOICES = pds_pkg::R_CHOICES_DEF,
  parameter int M_MAX     = pds_pkg::M_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pds_pkg::ctrl_t                ctrl,
  output pds_pkg::flags_t               flags,
  pds_stream_if.sink                    in_if,
  pds_stream_if.source                  out_if,
  input  logic                          cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pds_pkg::CFG_W-1:0]     cfg_wdata
);
  import pds_pkg::*;

  localparam int IW     = (R_CHOICES > 1) ? $clog2(R_CHOICES) : 1;
  localparam int MW     = $clog2(M_MAX + 1);
  localparam int RW     = $clog2(2 * R_CHOICES + 1);
  localparam int DVW    = FREQ_W + RW + MW;
  localparam int PROD_W = (DVW > REF_W + N_W) ? DVW : REF_W + N_W;
  localparam int MA_W   = (FREQ_W + MW > REF_W) ? FREQ_W + MW : REF_W;
  localparam int MB_W0  = (MW > RW) ? MW : RW;
  localparam int MB_W   = (MB_W0 > N_W) ? MB_W0 : N_W;

  logic [REF_W-1:0]  ref_r, ref_nxt;
  logic [FREQ_W-1:0] start_r, start_nxt;
  logic [FREQ_W-1:0] cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_pl_r, out_pl_nxt;

  logic              op_r, op_nxt;
  logic [TGT_W-1:0]  tgt_r, tgt_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [MW-1:0]     m_r, m_nxt;
  logic [REF_W-1:0]  vin_r, vin_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic              n_ok_r, n_ok_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              res_status_r, res_status_nxt;
  logic              res_chg_r, res_chg_nxt;
  logic [RC_W-1:0]   res_rc_r, res_rc_nxt;
  logic [MV_W-1:0]   res_m_r, res_m_nxt;
  logic [N_W-1:0]    res_n_r, res_n_nxt;

  logic [RW-1:0]        r_val;
  logic [MW+RW-1:0]     mr_prod;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [MA_W+MB_W-1:0] mul_full;
  logic                 div_start;
  logic                 div_busy;
  logic [PROD_W-1:0]    div_dvd;
  logic [REF_W-1:0]     div_dvs;
  logic [PROD_W-1:0]    quot;
  logic [WS_W-1:0]      ws;
  logic                 out_full;

  // R = 2 * (code + 1).
  assign r_val   = RW'({(IW + 1)'(i_r) + (IW + 1)'(1), 1'b0});
  assign mr_prod = (MW + RW)'(m_r) * (MW + RW)'(r_val);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_TM: begin
        mul_a = MA_W'(tgt_r[FREQ_W-1:0]);
        mul_b = MB_W'(m_r);
      end
      OP_MUL_R: begin
        mul_a = prod_r[MA_W-1:0];
        mul_b = MB_W'(r_val);
      end
      OP_MUL_VOUT: begin
        mul_a = MA_W'(vin_r);
        mul_b = MB_W'(n_r);
      end
      OP_MUL_REF_N: begin
        mul_a = MA_W'(ref_r);
        mul_b = MB_W'(n_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = (MA_W + MB_W)'(mul_a) * (MA_W + MB_W)'(mul_b);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod_r;
    div_dvs   = ref_r;
    case (ctrl.op)
      OP_DIV_VIN: begin
        div_start = 1'b1;
        div_dvd   = PROD_W'(ref_r);
        div_dvs   = REF_W'(m_r);
      end
      OP_DIV_N: begin
        div_start = 1'b1;
      end
      OP_DIV_F: begin
        div_start = 1'b1;
        div_dvs   = REF_W'(mr_prod);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  pds_div #(
    .DVD_W (PROD_W),
    .DVS_W (REF_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    if (cur_r <= WS0_LIM) begin
      ws = 3'd0;
    end else if (cur_r <= WS1_LIM) begin
      ws = 3'd1;
    end else if (cur_r <= WS2_LIM) begin
      ws = 3'd2;
    end else if (cur_r <= WS3_LIM) begin
      ws = 3'd3;
    end else begin
      ws = WS_TOP;
    end
  end

  assign out_full = out_valid_r && !out_if.ready;

  assign flags.no_in     = !in_if.valid;
  assign flags.is_init   = (op_r == OPC_INIT);
  assign flags.bad_range = (tgt_r < FREQ_MIN) || (tgt_r > FREQ_MAX);
  assign flags.same      = (tgt_r == TGT_W'(cur_r));
  assign flags.div_busy  = div_busy;
  assign flags.vin_bad   = (vin_r < VIN_MIN) || (vin_r > VIN_MAX);
  assign flags.n_bad     = !n_ok_r;
  assign flags.vout_bad  = (prod_r < PROD_W'(VOUT_MIN)) || (prod_r > PROD_W'(VOUT_MAX));
  assign flags.m_last    = (m_r == MW'(M_MAX));
  assign flags.r_last    = (i_r == IW'(R_CHOICES - 1));
  assign flags.out_full  = out_full;

  assign in_if.ready    = (ctrl.op == OP_ACCEPT);
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_pl_r;

  always_comb begin
    ref_nxt        = ref_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_pl_nxt     = out_pl_r;
    op_nxt         = op_r;
    tgt_nxt        = tgt_r;
    i_nxt          = i_r;
    m_nxt          = m_r;
    vin_nxt        = vin_r;
    n_nxt          = n_r;
    n_ok_nxt       = n_ok_r;
    prod_nxt       = prod_r;
    res_status_nxt = res_status_r;
    res_chg_nxt    = res_chg_r;
    res_rc_nxt     = res_rc_r;
    res_m_nxt      = res_m_r;
    res_n_nxt      = res_n_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_REF:   ref_nxt   = cfg_wdata[REF_W-1:0];
        CFG_START: start_nxt = cfg_wdata[FREQ_W-1:0];
        default:   ref_nxt   = ref_r;
      endcase
    end

    case (ctrl.op)
      OP_ACCEPT: begin
        if (in_if.valid) begin
          op_nxt  = in_if.payload.opcode;
          tgt_nxt = in_if.payload.target_freq_hz;
        end
      end
      OP_CLR: begin
        i_nxt = '0;
        m_nxt = MW'(1);
      end
      OP_LD_VIN: vin_nxt = quot[REF_W-1:0];
      OP_MUL_TM, OP_MUL_R, OP_MUL_VOUT, OP_MUL_REF_N: begin
        prod_nxt = PROD_W'(mul_full);
      end
      OP_LD_N: begin
        n_nxt    = quot[N_W-1:0];
        n_ok_nxt = (quot >= PROD_W'(N_MIN)) && (quot <= PROD_W'(N_MAX));
      end
      OP_LD_FOUND: begin
        cur_nxt        = quot[FREQ_W-1:0];
        res_status_nxt = 1'b0;
        res_chg_nxt    = 1'b1;
        res_rc_nxt     = RC_W'(i_r);
        res_m_nxt      = MV_W'(m_r);
        res_n_nxt      = n_r;
      end
      OP_INC_M: m_nxt = m_r + MW'(1);
      OP_INC_I: begin
        i_nxt = i_r + IW'(1);
        m_nxt = MW'(1);
      end
      OP_LD_INIT, OP_SET_OK, OP_SET_FAIL: begin
        if (ctrl.op == OP_LD_INIT) begin
          cur_nxt = start_r;
        end
        res_status_nxt = (ctrl.op == OP_SET_FAIL);
        res_chg_nxt    = 1'b0;
        res_rc_nxt     = '0;
        res_m_nxt      = '0;
        res_n_nxt      = '0;
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_valid_nxt               = 1'b1;
          out_pl_nxt.status           = res_status_r;
          out_pl_nxt.settings_changed = res_chg_r;
          out_pl_nxt.r_divider_code   = res_rc_r;
          out_pl_nxt.m_divider        = res_m_r;
          out_pl_nxt.n_multiplier     = res_n_r;
          out_pl_nxt.wait_states      = ws;
          out_pl_nxt.current_freq_hz  = cur_r;
        end
      end
      default: begin
        prod_nxt = prod_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= REF_RST;
      start_r     <= START_RST;
      cur_r       <= START_RST;
      out_valid_r <= 1'b0;
    end else begin
      ref_r       <= ref_nxt;
      start_r     <= start_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pl_r     <= out_pl_nxt;
    op_r         <= op_nxt;
    tgt_r        <= tgt_nxt;
    i_r          <= i_nxt;
    m_r          <= m_nxt;
    vin_r        <= vin_nxt;
    n_r          <= n_nxt;
    n_ok_r       <= n_ok_nxt;
    prod_r       <= prod_nxt;
    res_status_r <= res_status_nxt;
    res_chg_r    <= res_chg_nxt;
    res_rc_r     <= res_rc_nxt;
    res_m_r      <= res_m_nxt;
    res_n_r      <= res_n_nxt;
  end
endmodule

// ===== rtl/core/pds_checker.sv =====
// Port-level assertions for the PLL divider search block and their bind.
`timescale 1ns / 1ps
`include "pll_divider_search_top_macros.svh"
module pds_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pds_pkg::out_t out_payload
);
  import pds_pkg::*;

  // A stalled result holds still.
  `PDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "result changed while stalled")

  // Each result needs several steps, so none appears right after an acceptance.
  `PDS_ASSERT_NXT(a_no_instant, in_valid && in_ready, !$rose(out_valid), "result appeared too early")

  // Applied settings are always a success with N and M in range.
  `PDS_ASSERT_IMP(a_changed_ok, out_valid && out_payload.settings_changed, (out_payload.status == 1'b0) && (out_payload.n_multiplier >= N_MIN) && (out_payload.n_multiplier <= N_MAX) && (out_payload.m_divider != '0), "applied settings out of range")

  // Zero wait states exactly up to the first step.
  `PDS_ASSERT_IMP(a_ws_low, out_valid, (out_payload.wait_states == '0) == (out_payload.current_freq_hz <= WS0_LIM), "wait states do not match frequency")
endmodule

bind pll_divider_search_top pds_checker u_pds_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);
